FILE: hdl/integer_constant_intern_table_defines.svh
// Assertion macros shared by the intern table RTL.
`ifndef INTEGER_CONSTANT_INTERN_TABLE_DEFINES_SVH
`define INTEGER_CONSTANT_INTERN_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ICIT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("intern table assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ICIT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("intern table assertion failed");

`endif

FILE: hdl/icit_pkg.sv
package icit_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 64;
    localparam int unsigned VALUE_W         = 32;
    localparam int unsigned SLOT_W          = 6;

    localparam logic REQ_INTERN  = 1'b0;
    localparam logic REQ_CLEAR   = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic                       req_type;
        logic signed [VALUE_W-1:0]  value;
    } t_icit_req;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              already_present;
        logic              status;
    } t_icit_res;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_icit_state;

endpackage

FILE: hdl/icit_ram.sv
module icit_ram
    import icit_pkg::*;
#(
    parameter int unsigned WIDTH = VALUE_W,
    parameter int unsigned DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/integer_constant_intern_table.sv
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+---------------------
// request   | in        | start high, busy low   | i_req (t_icit_req)
// result    | out       | o_valid for one cycle  | o_result (t_icit_res)
//
// A clear request empties the table and gives its result without reading the RAM.
// An intern request reads one stored entry per cycle from a single RAM read port,
// stops at the first match, and otherwise appends the value unless the table is full.
// Busy stays high from acceptance until the cycle in which the result is shown.
// Synchronous active-low reset empties the table; stored entries are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "integer_constant_intern_table_defines.svh"

module integer_constant_intern_table
    import icit_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_icit_req i_req,
    output logic      o_valid,
    output t_icit_res o_result
);

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

    t_icit_state      r_state, n_state;
    t_icit_req        r_req,   n_req;
    logic [CNT_W-1:0] r_fill,  n_fill;
    logic [CNT_W-1:0] r_idx,   n_idx;
    logic [IDX_W-1:0] r_cidx,  n_cidx;
    logic             r_pend,  n_pend;
    logic             r_valid, n_valid;
    t_icit_res        r_res,   n_res;

    logic             ram_we;
    logic             ram_re;
    logic [VALUE_W-1:0] ram_rdata;

    icit_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill[IDX_W-1:0]),
        .i_wdata (r_req.value),
        .i_re    (ram_re),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_idx  <= n_idx;
        r_cidx <= n_cidx;
        r_res  <= n_res;
    end

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_fill  = r_fill;
        n_idx   = r_idx;
        n_cidx  = r_cidx;
        n_pend  = 1'b0;
        n_valid = 1'b0;
        n_res   = r_res;
        ram_we  = 1'b0;
        ram_re  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_idx   = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_req.req_type == REQ_CLEAR) begin
                    n_fill  = '0;
                    n_valid = 1'b1;
                    n_res   = '{slot: '0, already_present: 1'b0, status: STATUS_OK};
                    n_state = ST_IDLE;
                end else if (r_pend && (ram_rdata == r_req.value)) begin
                    n_valid = 1'b1;
                    n_res   = '{slot: SLOT_W'(r_cidx), already_present: 1'b1,
                                status: STATUS_OK};
                    n_state = ST_IDLE;
                end else if (r_idx < r_fill) begin
                    ram_re = 1'b1;
                    n_pend = 1'b1;
                    n_cidx = r_idx[IDX_W-1:0];
                    n_idx  = r_idx + CNT_W'(1);
                end else if (!r_pend) begin
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                    if (r_fill < CNT_W'(TABLE_DEPTH)) begin
                        ram_we = 1'b1;
                        n_fill = r_fill + CNT_W'(1);
                        n_res  = '{slot: SLOT_W'(r_fill[IDX_W-1:0]), already_present: 1'b0,
                                   status: STATUS_OK};
                    end else begin
                        n_res = '{slot: '0, already_present: 1'b0, status: STATUS_FULL};
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

    `ICIT_ASSERT_IMP(a_fill_bounded, i_clk, i_rst_n, 1'b1, r_fill <= CNT_W'(TABLE_DEPTH))
    `ICIT_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `ICIT_ASSERT_NXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid)
    `ICIT_ASSERT_IMP(a_result_flags, i_clk, i_rst_n, o_valid,
        !(o_result.already_present && (o_result.status == STATUS_FULL)))
    `ICIT_ASSERT_IMP(a_insert_grows, i_clk, i_rst_n,
        o_valid && (r_req.req_type == REQ_INTERN) && !o_result.already_present
            && (o_result.status == STATUS_OK),
        r_fill == ($past(r_fill) + CNT_W'(1)))

endmodule
